@@ design/fmtm_pkg.sv @@
// Package for the filmic tone map pixel core: widths, fixed-point constants and pipeline depth.
// It has no dependencies. The channel datapath and the top level use it.
package fmtm_pkg;

    localparam int CHANNEL_WIDTH = 20;
    localparam int GAIN_W        = 16;
    localparam int PROD_W        = CHANNEL_WIDTH + GAIN_W;
    localparam int X_W           = 21;
    localparam int SQ_W          = 2 * X_W;
    localparam int P16_W         = 36;
    localparam int D16_W         = 32;
    localparam int PL_W          = 40;
    localparam int DD_W          = 49;
    localparam int NUM_W         = 60;
    localparam int DEN_W         = 50;
    localparam int OUT_W         = 8;
    localparam int DIV_STEPS     = OUT_W;
    localparam int PIPE_DEPTH    = 8 + DIV_STEPS;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;

    localparam logic [63:0] ROUND_HALF = 64'd1020;
    localparam logic [63:0] X_CLAMP_T  = 64'd2040 << 20;
    localparam logic [63:0] X_CLAMP    = 64'd1 << 20;
    localparam logic [63:0] RECIP_255  = 64'd269488145;
    localparam int          RECIP_SH   = 36;
    localparam logic [63:0] P_SQ_K     = 64'd2100;
    localparam logic [63:0] P_X_K      = 64'd250;
    localparam logic [63:0] D_SQ_K     = 64'd150;
    localparam logic [63:0] D_X_K      = 64'd500;
    localparam logic [63:0] D_OFS      = 64'd60 << 16;
    localparam logic [63:0] OUT_NUM2   = 64'd3120690;
    localparam logic [63:0] OUT_DEN    = 64'd66556;

    localparam logic [1:0] REG_EXPOSURE_GAIN = 2'd0;

endpackage

@@ design/fmtm_channel.sv @@
// One color channel of the filmic tone map as a sixteen-stage pipeline.
// It depends on fmtm_pkg for widths and constants; all stages advance together on en.
module fmtm_channel
(
    input  logic                                 clk,
    input  logic                                 en,
    input  logic [fmtm_pkg::CHANNEL_WIDTH-1:0]   raw,
    input  logic [fmtm_pkg::GAIN_W-1:0]          gain,
    output logic [fmtm_pkg::OUT_W-1:0]           result
);

    localparam int PW = fmtm_pkg::PROD_W;
    localparam int NW = fmtm_pkg::NUM_W;
    localparam int BW = fmtm_pkg::DEN_W;
    localparam int QW = fmtm_pkg::OUT_W;

    logic [PW-1:0]                   prod_reg;
    logic [27:0]                     u_reg;
    logic                            clamp_reg;
    logic [fmtm_pkg::X_W-1:0]        x_reg;
    logic [fmtm_pkg::X_W-1:0]        x2_reg;
    logic [fmtm_pkg::SQ_W-1:0]       sq_reg;
    logic [fmtm_pkg::P16_W-1:0]      p16_reg;
    logic [fmtm_pkg::D16_W-1:0]      d16_reg;
    logic [fmtm_pkg::PL_W-1:0]       pl_reg;
    logic [fmtm_pkg::PL_W-1:0]       ph_reg;
    logic [fmtm_pkg::DD_W-1:0]       dd_reg;
    logic [NW-1:0]                   a_reg;
    logic [BW-1:0]                   b_reg;
    logic [NW-1:0]                   rem_reg [0:QW-1];
    logic [BW-1:0]                   den_reg [0:QW-1];
    logic                            sat_reg [0:QW];
    logic [QW-1:0]                   q_reg   [0:QW];

    logic [63:0]                     t_s;
    logic [56:0]                     mq_s;
    logic [fmtm_pkg::X_W-1:0]        x_next;
    logic [53:0]                     pmul_s;
    logic [49:0]                     dmul_s;
    logic [fmtm_pkg::P16_W-1:0]      p16_next;
    logic [fmtm_pkg::D16_W-1:0]      d16_next;

    always_comb
    begin
        t_s      = 64'(prod_reg) + fmtm_pkg::ROUND_HALF;
        mq_s     = 57'(u_reg) * 57'(fmtm_pkg::RECIP_255);
        x_next   = clamp_reg ? fmtm_pkg::X_W'(fmtm_pkg::X_CLAMP)
                             : mq_s[fmtm_pkg::RECIP_SH +: fmtm_pkg::X_W];
        pmul_s   = 54'(sq_reg) * 54'(fmtm_pkg::P_SQ_K);
        dmul_s   = 50'(sq_reg) * 50'(fmtm_pkg::D_SQ_K);
        p16_next = fmtm_pkg::P16_W'(pmul_s >> 16)
                 + fmtm_pkg::P16_W'(x2_reg) * fmtm_pkg::P16_W'(fmtm_pkg::P_X_K);
        d16_next = fmtm_pkg::D16_W'(dmul_s >> 16)
                 + fmtm_pkg::D16_W'(x2_reg) * fmtm_pkg::D16_W'(fmtm_pkg::D_X_K)
                 + fmtm_pkg::D16_W'(fmtm_pkg::D_OFS);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= PW'(raw) * PW'(gain);
            clamp_reg <= t_s >= fmtm_pkg::X_CLAMP_T;
            u_reg     <= t_s[30:3];
            x_reg     <= x_next;
            sq_reg    <= fmtm_pkg::SQ_W'(x_reg) * fmtm_pkg::SQ_W'(x_reg);
            x2_reg    <= x_reg;
            p16_reg   <= p16_next;
            d16_reg   <= d16_next;
            pl_reg    <= fmtm_pkg::PL_W'(p16_reg[17:0])
                       * fmtm_pkg::PL_W'(fmtm_pkg::OUT_NUM2);
            ph_reg    <= fmtm_pkg::PL_W'(p16_reg[35:18])
                       * fmtm_pkg::PL_W'(fmtm_pkg::OUT_NUM2);
            dd_reg    <= fmtm_pkg::DD_W'(d16_reg) * fmtm_pkg::DD_W'(fmtm_pkg::OUT_DEN);
            a_reg     <= (NW'(ph_reg) << 18) + NW'(pl_reg) + NW'(dd_reg);
            b_reg     <= BW'(dd_reg) << 1;
            rem_reg[0] <= a_reg;
            den_reg[0] <= b_reg;
            sat_reg[0] <= a_reg >= (NW'(b_reg) << QW);
            q_reg[0]   <= '0;
        end
    end

    for (genvar j = 0; j < QW; j++)
    begin : g_div
        logic [NW-1:0] shd_s;
        logic          fit_s;

        assign shd_s = NW'(den_reg[j]) << (QW - 1 - j);
        assign fit_s = rem_reg[j] >= shd_s;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sat_reg[j+1] <= sat_reg[j];
                q_reg[j+1]   <= q_reg[j] | (QW'(fit_s) << (QW - 1 - j));
            end
        end

        if (j < QW - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j+1] <= fit_s ? rem_reg[j] - shd_s : rem_reg[j];
                    den_reg[j+1] <= den_reg[j];
                end
            end
        end
    end

    assign result = sat_reg[QW] ? {QW{1'b1}} : q_reg[QW];

endmodule

@@ design/filmic_tonemap_pixel_core.sv @@
// Filmic tone map core: one HDR RGB pixel in, one 8-bit RGB pixel out, per item.
// It depends on fmtm_pkg and instantiates fmtm_channel once for each color channel.
//
// The core takes one item in every clock cycle unless stalled, through the channel
// pipeline, whose last eight stages each resolve one bit of the final quotient. All
// stages move together, so a stall at the output holds the whole pipeline and the
// input stall follows it in the same cycle. The user must write the exposure gain
// through the register port only while the core is idle; the core does not enforce it.
module filmic_tonemap_pixel_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [2:0]                           paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [fmtm_pkg::CHANNEL_WIDTH-1:0]   red_in,
    input  logic [fmtm_pkg::CHANNEL_WIDTH-1:0]   green_in,
    input  logic [fmtm_pkg::CHANNEL_WIDTH-1:0]   blue_in,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [fmtm_pkg::OUT_W-1:0]           red_out,
    output logic [fmtm_pkg::OUT_W-1:0]           green_out,
    output logic [fmtm_pkg::OUT_W-1:0]           blue_out
);

    logic [fmtm_pkg::GAIN_W-1:0]     gain_reg;
    logic [fmtm_pkg::PIPE_DEPTH-1:0] valid_reg;
    logic                            adv;
    logic                            sel_gain;

    assign adv       = !(valid_reg[fmtm_pkg::PIPE_DEPTH-1] && out_stall);
    assign in_stall  = !adv;
    assign out_valid = valid_reg[fmtm_pkg::PIPE_DEPTH-1];
    assign pready    = 1'b1;
    assign sel_gain  = {1'b0, paddr[2]} == fmtm_pkg::REG_EXPOSURE_GAIN;
    assign prdata    = sel_gain ? 32'(gain_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= fmtm_pkg::GAIN_RESET;
            valid_reg <= '0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && sel_gain)
            begin
                gain_reg <= pwdata[fmtm_pkg::GAIN_W-1:0];
            end
            if (adv)
            begin
                valid_reg <= {valid_reg[fmtm_pkg::PIPE_DEPTH-2:0], in_valid};
            end
        end
    end

    fmtm_channel u_red
    (
        .clk    (clk),
        .en     (adv),
        .raw    (red_in),
        .gain   (gain_reg),
        .result (red_out)
    );

    fmtm_channel u_green
    (
        .clk    (clk),
        .en     (adv),
        .raw    (green_in),
        .gain   (gain_reg),
        .result (green_out)
    );

    fmtm_channel u_blue
    (
        .clk    (clk),
        .en     (adv),
        .raw    (blue_in),
        .gain   (gain_reg),
        .result (blue_out)
    );

endmodule

@@ verif/tb_filmic_tonemap_pixel_core.sv @@
// Testbench for the filmic tone map pixel core: directed table, then random pixels.
// It depends on fmtm_pkg and the core; expected pixels are table values or predicted here.
module tb_filmic_tonemap_pixel_core;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_out_t;

    typedef struct {
        logic [fmtm_pkg::CHANNEL_WIDTH-1:0] red;
        logic [fmtm_pkg::CHANNEL_WIDTH-1:0] green;
        logic [fmtm_pkg::CHANNEL_WIDTH-1:0] blue;
        logic [fmtm_pkg::GAIN_W-1:0]        gain;
        bit                                 has_known;
        pixel_out_t                         known;
    } pixel_row_t;

    localparam int CYCLE_LIMIT = 400000;
    localparam logic [fmtm_pkg::CHANNEL_WIDTH-1:0] CH_MAX = '1;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    logic in_valid;
    logic in_stall;
    logic [fmtm_pkg::CHANNEL_WIDTH-1:0] red_in;
    logic [fmtm_pkg::CHANNEL_WIDTH-1:0] green_in;
    logic [fmtm_pkg::CHANNEL_WIDTH-1:0] blue_in;
    logic out_valid;
    logic out_stall;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;

    logic [fmtm_pkg::GAIN_W-1:0] model_gain;
    pixel_out_t expected_pixels[$];
    int mismatches;
    int cycles;
    bit stim_done;
    bit hold_request;

    filmic_tonemap_pixel_core u_top (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_filmic_tonemap_pixel_core: FAIL");
            $finish;
        end
    end

    function automatic logic [7:0] tone_value(logic [fmtm_pkg::CHANNEL_WIDTH-1:0] raw,
                                              logic [fmtm_pkg::GAIN_W-1:0] gain);
        logic [63:0] x;
        logic [63:0] p;
        logic [63:0] d;
        logic [63:0] q;
        x = (64'(raw) * 64'(gain) + 64'd1020) / 64'd2040;
        if (x > (64'd16 << 16))
            x = 64'd16 << 16;
        p = (x * (64'd2100 * x + (64'd250 << 16))) >> 16;
        d = (x * (64'd150 * x + (64'd500 << 16)) + (64'd60 << 32)) >> 16;
        q = (64'd3120690 * p + 64'd66556 * d) / (64'd133112 * d);
        return (q > 64'd255) ? 8'd255 : q[7:0];
    endfunction

    function automatic pixel_out_t tone_pixel(pixel_row_t r);
        pixel_out_t o;
        o.red = tone_value(r.red, model_gain);
        o.green = tone_value(r.green, model_gain);
        o.blue = tone_value(r.blue, model_gain);
        return o;
    endfunction

    task automatic write_gain(logic [fmtm_pkg::GAIN_W-1:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 3'(4 * fmtm_pkg::REG_EXPOSURE_GAIN);
        pwdata <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        model_gain = value;
    endtask

    task automatic wait_drained();
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (fmtm_pkg::PIPE_DEPTH + 4) @(posedge clk);
    endtask

    task automatic send_pixel(pixel_row_t r);
        if (r.has_known)
            expected_pixels.push_back(r.known);
        else
            expected_pixels.push_back(tone_pixel(r));
        in_valid <= 1'b1;
        red_in <= r.red;
        green_in <= r.green;
        blue_in <= r.blue;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(5, 30);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic logic [fmtm_pkg::CHANNEL_WIDTH-1:0] rand_channel();
        unique case ($urandom_range(0, 3))
            0: return fmtm_pkg::CHANNEL_WIDTH'($urandom_range(0, 255));
            1: return fmtm_pkg::CHANNEL_WIDTH'($urandom_range(0, 16383));
            2: return fmtm_pkg::CHANNEL_WIDTH'($urandom_range(0, 131071));
            default: return fmtm_pkg::CHANNEL_WIDTH'($urandom);
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_pixels.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected item: %0d %0d %0d", red_out, green_out, blue_out);
            end
            else
            begin
                pixel_out_t e;
                e = expected_pixels.pop_front();
                if (e.red !== red_out || e.green !== green_out || e.blue !== blue_out)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: expected %0d %0d %0d got %0d %0d %0d",
                                 e.red, e.green, e.blue, red_out, green_out, blue_out);
                end
            end
        end
    end

    initial
    begin
        int hold;
        out_stall = 1'b0;
        @(posedge rst_n);
        while (!stim_done)
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_stall <= 1'b1;
                hold = 0;
                while (hold < 80)
                begin
                    @(posedge clk);
                    hold++;
                end
                out_stall <= 1'b0;
            end
            else if ($urandom_range(0, 3) == 0)
                out_stall <= 1'b1;
            else if ($urandom_range(0, 5) == 0)
                out_stall <= ($urandom_range(0, 20) == 0);
            else
                out_stall <= 1'b0;
        end
        out_stall <= 1'b0;
    end

    initial
    begin
        pixel_row_t rows[$];
        pixel_row_t r;
        logic [fmtm_pkg::GAIN_W-1:0] gains[5];
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        red_in = '0;
        green_in = '0;
        blue_in = '0;
        stim_done = 1'b0;
        hold_request = 1'b0;
        model_gain = fmtm_pkg::GAIN_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows.push_back('{0, 0, 0, fmtm_pkg::GAIN_RESET, 1, '{8'd0, 8'd0, 8'd0}});
        rows.push_back('{CH_MAX, CH_MAX, CH_MAX, fmtm_pkg::GAIN_RESET, 1,
                         '{8'd255, 8'd255, 8'd255}});
        rows.push_back('{CH_MAX, 0, CH_MAX, fmtm_pkg::GAIN_RESET, 1,
                         '{8'd255, 8'd0, 8'd255}});
        rows.push_back('{1, 256, 65280, fmtm_pkg::GAIN_RESET, 0, '{0, 0, 0}});
        rows.push_back('{1428, 2856, 700, fmtm_pkg::GAIN_RESET, 0, '{0, 0, 0}});
        rows.push_back('{CH_MAX, CH_MAX, 0, 16'd0, 1, '{8'd0, 8'd0, 8'd0}});
        rows.push_back('{1, 2, 255, 16'hFFFF, 0, '{0, 0, 0}});
        rows.push_back('{CH_MAX, 100, 20'h55555, 16'hFFFF, 0, '{0, 0, 0}});
        rows.push_back('{20'hAAAAA, 20'h55555, 20'h80000, 16'd1, 0, '{0, 0, 0}});
        rows.push_back('{40000, 146000, 200000, fmtm_pkg::GAIN_RESET, 0, '{0, 0, 0}});
        foreach (rows[i])
        begin
            if (rows[i].gain != model_gain)
            begin
                in_valid <= 1'b0;
                wait_drained();
                write_gain(rows[i].gain);
            end
            send_pixel(rows[i]);
        end
        in_valid <= 1'b0;
        wait_drained();

        gains = '{fmtm_pkg::GAIN_RESET, 16'hFFFF, 16'd0, 16'd1, 16'd12000};
        for (int phase = 0; phase < 6; phase++)
        begin
            write_gain(phase < 5 ? gains[phase] : 16'($urandom));
            for (int k = 0; k < 85; k++)
            begin
                r.red = rand_channel();
                r.green = rand_channel();
                r.blue = rand_channel();
                r.has_known = 0;
                if (phase == 1 && k == 20)
                    hold_request = 1'b1;
                if (phase == 1 && k == 22)
                    hold_request = 1'b0;
                send_pixel(r);
                if (k % 9 == 8)
                    idle_gap();
                else if ($urandom_range(0, 3) == 0)
                    idle_gap();
            end
            in_valid <= 1'b0;
            wait_drained();
        end
        stim_done = 1'b1;
        wait_drained();

        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("tb_filmic_tonemap_pixel_core: PASS");
        else
            $display("tb_filmic_tonemap_pixel_core: FAIL");
        $finish;
    end

endmodule
